### src/bse_pkg.sv
package bse_pkg;

   localparam int FRAC_BITS      = 28;
   localparam int REG_FRAC       = 28;
   localparam int INDEX_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF = 12;

   localparam int ZW   = FRAC_BITS + 3;
   localparam int CW   = FRAC_BITS + 4;
   localparam int PW   = 2 * ZW;
   localparam int SQW  = PW - FRAC_BITS;
   localparam int XYW  = PW - FRAC_BITS + 1;
   localparam int SUMW = SQW + 1;
   localparam int RW   = FRAC_BITS + 9;

   localparam int SH_UP = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
   localparam int SH_DN = (FRAC_BITS >= REG_FRAC) ? 0 : REG_FRAC - FRAC_BITS;

   localparam int HUE_BITS  = 9;
   localparam int HUE_RANGE = 360;

   localparam int CSR_AW    = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_REAL  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_STEP_REAL    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IMAG  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ITER_CAP     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_HUE_OFFSET   = 3'd6;

   localparam logic signed [31:0] ORIGIN_RST       = -32'sd536870912;
   localparam logic [30:0]        STEP_RST         = 31'd1048576;
   localparam logic [2:0]         ESCAPE_LIMIT_RST = 3'd4;
   localparam int                 ITER_CAP_RST     = 255;
   localparam logic [8:0]         HUE_OFFSET_RST   = 9'd0;

   typedef struct packed {
      logic signed [31:0] origin_real;
      logic [30:0]        step_real;
      logic signed [31:0] origin_imag;
      logic [30:0]        step_imag;
      logic [2:0]         escape_limit;
      logic [8:0]         hue_offset;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic init;
      logic mul;
      logic update;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic in_set;
      logic div_last;
      logic out_free;
   } sts_type;

   function automatic logic signed [CW-1:0] to_frac(input logic signed [31:0] v);
      logic signed [63:0] w;
      begin
         w = 64'(v);
         w = (w <<< SH_UP) >>> SH_DN;
         return w[CW-1:0];
      end
   endfunction

endpackage

### src/bse_csr.sv
module bse_csr #(
   parameter int COUNT_BITS = bse_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bse_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output bse_pkg::cfg_type            cfg,
   output logic [COUNT_BITS-1:0]       iteration_cap
);
   import bse_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic [COUNT_BITS-1:0]  cap_ff, cap_in;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      cap_in = cap_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ORIGIN_REAL:  cfg_in.origin_real  = pwdata;
            REG_STEP_REAL:    cfg_in.step_real    = pwdata[30:0];
            REG_ORIGIN_IMAG:  cfg_in.origin_imag  = pwdata;
            REG_STEP_IMAG:    cfg_in.step_imag    = pwdata[30:0];
            REG_ESCAPE_LIMIT: cfg_in.escape_limit = pwdata[2:0];
            REG_ITER_CAP:     cap_in              = pwdata[COUNT_BITS-1:0];
            REG_HUE_OFFSET:   cfg_in.hue_offset   = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_real  <= ORIGIN_RST;
         cfg_ff.step_real    <= STEP_RST;
         cfg_ff.origin_imag  <= ORIGIN_RST;
         cfg_ff.step_imag    <= STEP_RST;
         cfg_ff.escape_limit <= ESCAPE_LIMIT_RST;
         cfg_ff.hue_offset   <= HUE_OFFSET_RST;
         cap_ff              <= COUNT_BITS'(ITER_CAP_RST);
      end else begin
         cfg_ff <= cfg_in;
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_ORIGIN_REAL:  prdata = cfg_ff.origin_real;
         REG_STEP_REAL:    prdata = {1'b0, cfg_ff.step_real};
         REG_ORIGIN_IMAG:  prdata = cfg_ff.origin_imag;
         REG_STEP_IMAG:    prdata = {1'b0, cfg_ff.step_imag};
         REG_ESCAPE_LIMIT: prdata = 32'(cfg_ff.escape_limit);
         REG_ITER_CAP:     prdata = 32'(cap_ff);
         REG_HUE_OFFSET:   prdata = 32'(cfg_ff.hue_offset);
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg           = cfg_ff;
   assign iteration_cap = cap_ff;

endmodule

### src/bse_ctrl.sv
module bse_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output bse_pkg::cmd_type  cmd,
   input  bse_pkg::sts_type  sts
);
   import bse_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAP  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_HUE  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MAP;
            end
         end
         S_MAP: begin
            cmd.init = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (!sts.stop) begin
               cmd.update = 1'b1;
               state_in   = S_MUL;
            end else if (sts.in_set) begin
               state_in = S_HUE;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_HUE;
            end
         end
         S_HUE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/bse_dp.sv
module bse_dp #(
   parameter int INDEX_BITS = bse_pkg::INDEX_BITS_DEF,
   parameter int COUNT_BITS = bse_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bse_pkg::cmd_type              cmd,
   output bse_pkg::sts_type              sts,
   input  bse_pkg::cfg_type              cfg,
   input  logic [COUNT_BITS-1:0]         iteration_cap,
   input  logic [INDEX_BITS-1:0]         req_column,
   input  logic [INDEX_BITS-1:0]         req_row_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [COUNT_BITS-1:0]         rsp_iteration_count,
   output logic                          rsp_inside_res,
   output logic [bse_pkg::HUE_BITS-1:0]  rsp_hue
);
   import bse_pkg::*;

   localparam int MPW  = INDEX_BITS + 31;
   localparam int MSW  = MPW + 2;
   localparam int DIVW = COUNT_BITS + HUE_BITS;
   localparam int DCW  = $clog2(HUE_BITS);
   localparam logic [HUE_BITS:0] HR1 = (HUE_BITS + 1)'(HUE_RANGE);
   localparam logic [HUE_BITS:0] HR2 = (HUE_BITS + 1)'(2 * HUE_RANGE);

   logic [MPW-1:0]           mre_ff, mre_in, mim_ff, mim_in;
   logic signed [CW-1:0]     cr_ff, cr_in, ci_ff, ci_in;
   logic [ZW-1:0]            x_ff, x_in, y_ff, y_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SQW-1:0]           xx_ff, xx_in, yy_ff, yy_in;
   logic [XYW-1:0]           xy2_ff, xy2_in;
   logic [DIVW-1:0]          rem_ff, rem_in, dsor_ff, dsor_in;
   logic [HUE_BITS-1:0]      quot_ff, quot_in;
   logic [DCW-1:0]           dcnt_ff, dcnt_in;
   logic                     vld_ff, vld_in;
   logic [COUNT_BITS-1:0]    ocnt_ff, ocnt_in;
   logic                     oins_ff, oins_in;
   logic [HUE_BITS-1:0]      ohue_ff, ohue_in;

   logic signed [MSW-1:0]    sre, sim;
   logic [PW-1:0]            pxx, pyy, pxy;
   logic signed [RW-1:0]     re, im;
   logic [RW-1:0]            mag_re, mag_im;
   logic [ZW-1:0]            zx, zy;
   logic [SUMW-1:0]          mag2, bound;
   logic                     in_set, ge;
   logic [HUE_BITS:0]        hsum, hmod;
   logic [HUE_BITS-1:0]      hue_val;

   function automatic logic signed [31:0] sat32(input logic signed [MSW-1:0] s);
      begin
         if ((&s[MSW-1:31]) || !(|s[MSW-1:31])) begin
            return s[31:0];
         end else if (s[MSW-1]) begin
            return 32'sh8000_0000;
         end else begin
            return 32'sh7fff_ffff;
         end
      end
   endfunction

   always_comb begin
      sre = MSW'(cfg.origin_real) + $signed({2'b00, mre_ff});
      sim = MSW'(cfg.origin_imag) + $signed({2'b00, mim_ff});

      pxx = PW'(x_ff) * PW'(x_ff);
      pyy = PW'(y_ff) * PW'(y_ff);
      pxy = PW'(x_ff) * PW'(y_ff);

      re = $signed({3'b000, xx_ff}) - $signed({3'b000, yy_ff}) + RW'(cr_ff);
      im = $signed({2'b00, xy2_ff}) + RW'(ci_ff);
      mag_re = re[RW-1] ? -re : re;
      mag_im = im[RW-1] ? -im : im;
      zx = (|mag_re[RW-1:ZW]) ? {ZW{1'b1}} : mag_re[ZW-1:0];
      zy = (|mag_im[RW-1:ZW]) ? {ZW{1'b1}} : mag_im[ZW-1:0];

      mag2  = {1'b0, xx_ff} + {1'b0, yy_ff};
      bound = SUMW'(cfg.escape_limit) << FRAC_BITS;

      in_set = (cnt_ff == iteration_cap);
      ge     = (rem_ff >= dsor_ff);

      hsum = {1'b0, quot_ff} + {1'b0, cfg.hue_offset};
      priority if (hsum >= HR2) begin
         hmod = hsum - HR2;
      end else if (hsum >= HR1) begin
         hmod = hsum - HR1;
      end else begin
         hmod = hsum;
      end
      hue_val = in_set ? '0 : hmod[HUE_BITS-1:0];
   end

   always_comb begin
      sts.stop     = in_set || !(mag2 < bound);
      sts.in_set   = in_set;
      sts.div_last = (dcnt_ff == '0);
      sts.out_free = !vld_ff || rsp_ready;
   end

   always_comb begin
      mre_in  = mre_ff;
      mim_in  = mim_ff;
      cr_in   = cr_ff;
      ci_in   = ci_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      xx_in   = xx_ff;
      yy_in   = yy_ff;
      xy2_in  = xy2_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quot_in = quot_ff;
      dcnt_in = dcnt_ff;
      ocnt_in = ocnt_ff;
      oins_in = oins_ff;
      ohue_in = ohue_ff;
      vld_in  = vld_ff && !rsp_ready;

      if (cmd.accept) begin
         mre_in = MPW'(req_column) * MPW'(cfg.step_real);
         mim_in = MPW'(req_row_index) * MPW'(cfg.step_imag);
      end
      if (cmd.init) begin
         cr_in  = to_frac(sat32(sre));
         ci_in  = to_frac(sat32(sim));
         x_in   = '0;
         y_in   = '0;
         cnt_in = '0;
      end
      if (cmd.mul) begin
         xx_in  = pxx[PW-1:FRAC_BITS];
         yy_in  = pyy[PW-1:FRAC_BITS];
         xy2_in = pxy[PW-1:FRAC_BITS-1];
      end
      if (cmd.update) begin
         x_in   = zx;
         y_in   = zy;
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.div_load) begin
         rem_in  = DIVW'(cnt_ff) * DIVW'(HUE_RANGE);
         dsor_in = DIVW'(iteration_cap) << (HUE_BITS - 1);
         quot_in = '0;
         dcnt_in = DCW'(HUE_BITS - 1);
      end
      if (cmd.div_step) begin
         if (ge) begin
            rem_in = rem_ff - dsor_ff;
         end
         quot_in = {quot_ff[HUE_BITS-2:0], ge};
         dsor_in = dsor_ff >> 1;
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         ocnt_in = cnt_ff;
         oins_in = in_set;
         ohue_in = hue_val;
         vld_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mre_ff  <= mre_in;
      mim_ff  <= mim_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cnt_ff  <= cnt_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      xy2_ff  <= xy2_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quot_ff <= quot_in;
      dcnt_ff <= dcnt_in;
      ocnt_ff <= ocnt_in;
      oins_ff <= oins_in;
      ohue_ff <= ohue_in;
   end

   assign rsp_valid           = vld_ff;
   assign rsp_iteration_count = ocnt_ff;
   assign rsp_inside_res      = oins_ff;
   assign rsp_hue             = ohue_ff;

endmodule

### src/burning_ship_escape_time_top.sv
// An escaped pixel passes through the hue divider before rsp_valid; an inside
// pixel skips the divider and goes straight to the hue state.
// Each iteration passes through the multiply state and then the update state;
// the hue divider yields its nine quotient bits, one quotient bit per cycle.
// One pixel at a time; the next req beat is taken while a result waits on rsp.
// Synchronous active-high reset: idle, no result held, registers at defaults.
module burning_ship_escape_time_top #(
   parameter int INDEX_BITS = bse_pkg::INDEX_BITS_DEF,
   parameter int COUNT_BITS = bse_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INDEX_BITS-1:0]         req_column,
   input  logic [INDEX_BITS-1:0]         req_row_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COUNT_BITS-1:0]         rsp_iteration_count,
   output logic                          rsp_inside_res,
   output logic [bse_pkg::HUE_BITS-1:0]  rsp_hue,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bse_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bse_pkg::*;

   cfg_type                cfg;
   logic [COUNT_BITS-1:0]  iteration_cap;
   cmd_type                cmd;
   sts_type                sts;

   bse_csr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .cfg           (cfg),
      .iteration_cap (iteration_cap)
   );

   bse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bse_dp #(
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .cfg                 (cfg),
      .iteration_cap       (iteration_cap),
      .req_column          (req_column),
      .req_row_index       (req_row_index),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_inside_res      (rsp_inside_res),
      .rsp_hue             (rsp_hue)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a req beat");

   a_inside_hue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_hue == '0)
      else $error("inside pixel carries a nonzero hue");

   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_iteration_count == iteration_cap)
      else $error("inside pixel count differs from the cap");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_BITS'(HUE_RANGE))
      else $error("hue out of range");

endmodule
